### hw/rtl/wdm_pkg.sv
// shared constants, types and helper functions of the wall density map
package wdm_pkg;

	localparam int MAX_WIDTH     = 256;
	localparam int MAX_HEIGHT    = 256;
	localparam int WINDOW_RADIUS = 9;
	localparam int QUERY_RADIUS  = 1;

	localparam int COUNT_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int WORD_W  = COUNT_W + 1;

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int MAX_R = (WINDOW_RADIUS > QUERY_RADIUS) ? WINDOW_RADIUS : QUERY_RADIUS;
	localparam int CNT_W = $clog2(2 * MAX_R + 1);

	localparam int POS_W  = 11;
	localparam int KIND_W = 2;
	localparam int CFG_W  = 9;

	localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W   = $clog2(DIM_MAX + 1);
	// room for pos plus origin plus radius, and for a signed compare against the size
	localparam int COORD_W = ((DIM_W + 1 > 13) ? DIM_W + 1 : 13) + 1;

	localparam int APB_W   = 32;
	localparam int PADDR_W = 4;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_ORIGIN_X    = 2'd2,
		REG_ORIGIN_Y    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CTR_RD,
		ST_CTR_CHK,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		dim_t             width;
		dim_t             height;
		logic [CFG_W-1:0] origin_x;
		logic [CFG_W-1:0] origin_y;
	} cfg_t;

	typedef struct packed {
		logic out_of_range;
		logic legal;
		logic changed;
	} result_t;

	function automatic logic on_grid(coord_t x, coord_t y, dim_t w, dim_t h);
		logic x_ok;
		logic y_ok;
		x_ok = !x[COORD_W-1] && ($unsigned(x) < COORD_W'(w));
		y_ok = !y[COORD_W-1] && ($unsigned(y) < COORD_W'(h));
		return x_ok && y_ok;
	endfunction

	function automatic addr_t map_addr(coord_t x, coord_t y);
		addr_t a;
		a = ADDR_W'(x[XW-1:0]) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(y[YW-1:0]);
		return a;
	endfunction

endpackage

### hw/rtl/wdm_ram.sv
// generic simple dual-port ram with registered read
module wdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/wdm_cfg.sv
// apb register file for grid size and query origin
module wdm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wdm_pkg::PADDR_W-1:0]     paddr,
	input  logic [wdm_pkg::APB_W-1:0]       pwdata,
	output logic [wdm_pkg::APB_W-1:0]       prdata,
	output logic                            pready,
	output wdm_pkg::cfg_t                   cfg
);

	logic [wdm_pkg::CFG_W-1:0] grid_w_q;
	logic [wdm_pkg::CFG_W-1:0] grid_h_q;
	logic [wdm_pkg::CFG_W-1:0] org_x_q;
	logic [wdm_pkg::CFG_W-1:0] org_y_q;
	wdm_pkg::reg_idx_t idx;
	logic wr;

	assign pready = 1'b1;
	assign idx    = wdm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= wdm_pkg::CFG_W'(256);
			grid_h_q <= wdm_pkg::CFG_W'(256);
			org_x_q  <= wdm_pkg::CFG_W'(128);
			org_y_q  <= wdm_pkg::CFG_W'(128);
		end else if (wr) begin
			unique case (idx)
				wdm_pkg::REG_GRID_WIDTH:  grid_w_q <= pwdata[wdm_pkg::CFG_W-1:0];
				wdm_pkg::REG_GRID_HEIGHT: grid_h_q <= pwdata[wdm_pkg::CFG_W-1:0];
				wdm_pkg::REG_ORIGIN_X:    org_x_q  <= pwdata[wdm_pkg::CFG_W-1:0];
				wdm_pkg::REG_ORIGIN_Y:    org_y_q  <= pwdata[wdm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wdm_pkg::REG_GRID_WIDTH:  prdata = wdm_pkg::APB_W'(grid_w_q);
			wdm_pkg::REG_GRID_HEIGHT: prdata = wdm_pkg::APB_W'(grid_h_q);
			wdm_pkg::REG_ORIGIN_X:    prdata = wdm_pkg::APB_W'(org_x_q);
			wdm_pkg::REG_ORIGIN_Y:    prdata = wdm_pkg::APB_W'(org_y_q);
			default:                  prdata = '0;
		endcase
	end

	// sizes above the store dimensions are clamped
	always_comb begin
		if (32'(grid_w_q) > 32'(wdm_pkg::MAX_WIDTH)) begin
			cfg.width = wdm_pkg::DIM_W'(wdm_pkg::MAX_WIDTH);
		end else begin
			cfg.width = wdm_pkg::DIM_W'(grid_w_q);
		end
		if (32'(grid_h_q) > 32'(wdm_pkg::MAX_HEIGHT)) begin
			cfg.height = wdm_pkg::DIM_W'(wdm_pkg::MAX_HEIGHT);
		end else begin
			cfg.height = wdm_pkg::DIM_W'(grid_h_q);
		end
		cfg.origin_x = org_x_q;
		cfg.origin_y = org_y_q;
	end

endmodule

### hw/rtl/wdm_ctrl.sv
// sequencer: clearing pass, window read-modify-write, query scan, result register
module wdm_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wdm_pkg::cfg_t                      cfg,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [wdm_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [wdm_pkg::KIND_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [wdm_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               ram_we,
	output wdm_pkg::addr_t                     ram_waddr,
	output logic [wdm_pkg::WORD_W-1:0]         ram_wdata,
	output wdm_pkg::addr_t                     ram_raddr,
	input  logic [wdm_pkg::WORD_W-1:0]         ram_rdata
);

	localparam int CW = wdm_pkg::COUNT_W;

	wdm_pkg::state_t state_q, state_d;
	wdm_pkg::addr_t  clr_q;
	logic            want_q;
	logic            qry_q;
	wdm_pkg::coord_t bx_q, by_q;
	logic [wdm_pkg::CNT_W-1:0] dx_q, dy_q;
	logic            chk_s1;
	wdm_pkg::addr_t  addr_s1;
	logic            ctr_s1;
	wdm_pkg::result_t res_q;
	wdm_pkg::result_t odata_q;
	logic            ovalid_q;

	wdm_pkg::kind_t  in_kind;
	wdm_pkg::coord_t in_x, in_y;
	logic            in_ok;
	logic [wdm_pkg::CNT_W-1:0] rad, span;
	wdm_pkg::coord_t px, py;
	logic            pos_ok;
	wdm_pkg::addr_t  pos_addr;
	logic            last_pos;
	logic            accept;
	logic            out_load;
	logic [CW-1:0]   cnt, cnt_new;

	assign in_kind = wdm_pkg::kind_t'(s_tuser);
	assign in_x    = wdm_pkg::coord_t'($signed(s_tdata[wdm_pkg::POS_W-1:0]));
	assign in_y    = wdm_pkg::coord_t'($signed(s_tdata[2*wdm_pkg::POS_W-1:wdm_pkg::POS_W]));
	assign in_ok   = wdm_pkg::on_grid(in_x, in_y, cfg.width, cfg.height);

	assign rad  = qry_q ? wdm_pkg::CNT_W'(wdm_pkg::QUERY_RADIUS)
	                    : wdm_pkg::CNT_W'(wdm_pkg::WINDOW_RADIUS);
	assign span = qry_q ? wdm_pkg::CNT_W'(2 * wdm_pkg::QUERY_RADIUS)
	                    : wdm_pkg::CNT_W'(2 * wdm_pkg::WINDOW_RADIUS);
	assign px   = bx_q + wdm_pkg::coord_t'(dx_q) - wdm_pkg::coord_t'(rad);
	assign py   = by_q + wdm_pkg::coord_t'(dy_q) - wdm_pkg::coord_t'(rad);
	assign pos_ok   = wdm_pkg::on_grid(px, py, cfg.width, cfg.height);
	assign pos_addr = wdm_pkg::map_addr(px, py);
	assign last_pos = (dx_q == span) && (dy_q == span);

	assign accept = s_tvalid && s_tready;

	// count update for the entry read in the previous cycle, saturating both ways
	assign cnt = ram_rdata[CW-1:0];
	always_comb begin
		if (want_q) begin
			cnt_new = (cnt != wdm_pkg::COUNT_MAX) ? cnt + CW'(1) : cnt;
		end else begin
			cnt_new = (cnt != '0) ? cnt - CW'(1) : cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wdm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		ram_raddr = pos_addr;
		ram_we    = chk_s1 && !qry_q;
		ram_waddr = addr_s1;
		ram_wdata = {ctr_s1 ? want_q : ram_rdata[CW], cnt_new};
		unique case (state_q)
			wdm_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == wdm_pkg::ADDR_W'(wdm_pkg::DEPTH - 1)) begin
					state_d = wdm_pkg::ST_IDLE;
				end
			end
			wdm_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_kind)
						wdm_pkg::KIND_SET, wdm_pkg::KIND_CLEAR: begin
							state_d = in_ok ? wdm_pkg::ST_CTR_RD : wdm_pkg::ST_DONE;
						end
						wdm_pkg::KIND_QUERY: state_d = wdm_pkg::ST_SCAN;
						default:             state_d = wdm_pkg::ST_DONE;
					endcase
				end
			end
			wdm_pkg::ST_CTR_RD: begin
				ram_raddr = wdm_pkg::map_addr(bx_q, by_q);
				state_d   = wdm_pkg::ST_CTR_CHK;
			end
			wdm_pkg::ST_CTR_CHK: begin
				state_d = (ram_rdata[CW] == want_q) ? wdm_pkg::ST_DONE : wdm_pkg::ST_SCAN;
			end
			wdm_pkg::ST_SCAN: begin
				if (last_pos) begin
					state_d = wdm_pkg::ST_DRAIN;
				end
			end
			wdm_pkg::ST_DRAIN: state_d = wdm_pkg::ST_DONE;
			wdm_pkg::ST_DONE: begin
				if (!ovalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = wdm_pkg::ST_IDLE;
				end
			end
			default: state_d = wdm_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			chk_s1   <= 1'b0;
			dx_q     <= '0;
			dy_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == wdm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + wdm_pkg::ADDR_W'(1);
			end
			chk_s1 <= (state_q == wdm_pkg::ST_SCAN) && pos_ok;
			if (accept) begin
				dx_q <= '0;
				dy_q <= '0;
			end else if (state_q == wdm_pkg::ST_SCAN) begin
				if (dy_q == span) begin
					dy_q <= '0;
					dx_q <= dx_q + wdm_pkg::CNT_W'(1);
				end else begin
					dy_q <= dy_q + wdm_pkg::CNT_W'(1);
				end
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= pos_addr;
		ctr_s1  <= (dx_q == rad) && (dy_q == rad);
		if (accept) begin
			want_q <= (in_kind == wdm_pkg::KIND_SET);
			qry_q  <= (in_kind == wdm_pkg::KIND_QUERY);
			case (in_kind)
				wdm_pkg::KIND_SET, wdm_pkg::KIND_CLEAR: begin
					bx_q  <= in_x;
					by_q  <= in_y;
					res_q <= '{out_of_range: !in_ok, legal: 1'b0, changed: 1'b0};
				end
				wdm_pkg::KIND_QUERY: begin
					bx_q  <= in_x + wdm_pkg::coord_t'(cfg.origin_x);
					by_q  <= in_y + wdm_pkg::coord_t'(cfg.origin_y);
					res_q <= '{out_of_range: 1'b0, legal: 1'b1, changed: 1'b0};
				end
				default: begin
					bx_q  <= in_x;
					by_q  <= in_y;
					res_q <= '0;
				end
			endcase
		end
		if (state_q == wdm_pkg::ST_CTR_CHK && ram_rdata[CW] != want_q) begin
			res_q.changed <= 1'b1;
		end
		// a neighbor off the grid or with a wall nearby spoils the query
		if (qry_q && ((state_q == wdm_pkg::ST_SCAN && !pos_ok) || (chk_s1 && cnt != '0))) begin
			res_q.legal <= 1'b0;
		end
		if (out_load) begin
			odata_q <= res_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = wdm_pkg::OUT_DATA_W'(odata_q);

	a_no_accept_twice: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while previous item still in work");

	a_wb_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != wdm_pkg::ST_CLEAR) |-> ram_waddr == $past(ram_raddr))
		else $error("count write-back address differs from the read issued before");

	a_ctr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wdm_pkg::ST_SCAN) |-> (dx_q <= span && dy_q <= span))
		else $error("window counter out of range");

	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		(qry_q && (state_q == wdm_pkg::ST_SCAN || state_q == wdm_pkg::ST_DRAIN)) |-> !ram_we)
		else $error("store written during a query");

	a_clear_gates_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wdm_pkg::ST_CLEAR) |-> (!s_tready && !m_tvalid))
		else $error("channel active during clearing pass");

endmodule

### hw/rtl/wall_density_map_update.sv
// top level of the wall density map: registers, sequencer and map store
// a set/clear that flips a pixel walks the whole (2*WINDOW_RADIUS+1)^2 window, one with no
// change only reads the pixel, an off-grid or unused kind goes straight to the result, a query
// walks the (2*QUERY_RADIUS+1)^2 window; one item is in work at a time, set by the single
// read and write port pair of the map store walking the window one entry per cycle
// after reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT entries
// with s_tready low; configuration writes are taken throughout
module wall_density_map_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [wdm_pkg::IN_DATA_W-1:0]      s_tdata,  // pos_x[10:0], pos_y[21:11], zero
	input  logic [wdm_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [wdm_pkg::OUT_DATA_W-1:0]     m_tdata,  // changed[0], legal[1], out_of_range[2]
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wdm_pkg::PADDR_W-1:0]        paddr,
	input  logic [wdm_pkg::APB_W-1:0]          pwdata,
	output logic [wdm_pkg::APB_W-1:0]          prdata,
	output logic                               pready
);

	wdm_pkg::cfg_t  cfg;
	logic           ram_we;
	wdm_pkg::addr_t ram_waddr;
	wdm_pkg::addr_t ram_raddr;
	logic [wdm_pkg::WORD_W-1:0] ram_wdata;
	logic [wdm_pkg::WORD_W-1:0] ram_rdata;

	wdm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// each word holds the wall bit above the window count
	wdm_ram #(
		.WIDTH (wdm_pkg::WORD_W),
		.DEPTH (wdm_pkg::DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### verif/tb_top.sv
// testbench for the wall density map: directed and random map edits and spawn queries
`timescale 1ns / 1ps

module tb_top;
	import wdm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 400;
	localparam int SHOW_LIMIT     = 10;
	localparam int RECENT_MAX     = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // pos_x[10:0], pos_y[21:11], zero
	logic [KIND_W-1:0]     s_tuser;   // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // changed[0], legal[1], out_of_range[2]
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [APB_W-1:0]      pwdata;
	logic [APB_W-1:0]      prdata;
	logic                  pready;

	wall_density_map_update dut (.*);

	// map state as the block should hold it
	bit               wall_map   [DEPTH];
	bit [COUNT_W-1:0] wall_count [DEPTH];
	logic [CFG_W-1:0] size_x  = 9'd256;
	logic [CFG_W-1:0] size_y  = 9'd256;
	logic [CFG_W-1:0] shift_x = 9'd128;
	logic [CFG_W-1:0] shift_y = 9'd128;

	result_t pending_flags[$];
	int      recent_walls[$];
	int      mismatches;
	int      quiet_cycles;
	bit      stalls_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int used_width();
		return (int'(size_x) > MAX_WIDTH) ? MAX_WIDTH : int'(size_x);
	endfunction

	function automatic int used_height();
		return (int'(size_y) > MAX_HEIGHT) ? MAX_HEIGHT : int'(size_y);
	endfunction

	function automatic bit on_map(int x, int y);
		return x >= 0 && y >= 0 && x < used_width() && y < used_height();
	endfunction

	function automatic void spread_wall(int x, int y, bit up);
		int px;
		int py;
		int a;
		for (int dx = -WINDOW_RADIUS; dx <= WINDOW_RADIUS; dx++) begin
			for (int dy = -WINDOW_RADIUS; dy <= WINDOW_RADIUS; dy++) begin
				px = x + dx;
				py = y + dy;
				if (on_map(px, py)) begin
					a = px * MAX_HEIGHT + py;
					// counts stick at both ends instead of wrapping
					if (up && wall_count[a] != COUNT_MAX)
						wall_count[a]++;
					else if (!up && wall_count[a] != 0)
						wall_count[a]--;
				end
			end
		end
	endfunction

	function automatic result_t apply_map_item(logic [KIND_W-1:0] kind, int x, int y);
		result_t r;
		int a;
		int cx;
		int cy;
		bit want;
		r = '0;
		if (kind == KIND_SET || kind == KIND_CLEAR) begin
			if (!on_map(x, y)) begin
				r.out_of_range = 1'b1;
			end else begin
				a = x * MAX_HEIGHT + y;
				want = (kind == KIND_SET);
				if (wall_map[a] != want) begin
					wall_map[a] = want;
					r.changed = 1'b1;
					spread_wall(x, y, want);
					if (want) begin
						recent_walls.insert(recent_walls.size(), a);
						if (recent_walls.size() > RECENT_MAX)
							void'(recent_walls.pop_front());
					end
				end
			end
		end else if (kind == KIND_QUERY) begin
			cx = x + int'(shift_x);
			cy = y + int'(shift_y);
			r.legal = 1'b1;
			for (int dx = -QUERY_RADIUS; dx <= QUERY_RADIUS; dx++) begin
				for (int dy = -QUERY_RADIUS; dy <= QUERY_RADIUS; dy++) begin
					if (!on_map(cx + dx, cy + dy) ||
					    wall_count[(cx + dx) * MAX_HEIGHT + cy + dy] != 0)
						r.legal = 1'b0;
				end
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [APB_W-1:0] want,
	                             input logic [APB_W-1:0] got);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
	endtask

	// one request in flight from here at a time, so predictions stay in order
	task automatic send_item(input logic [KIND_W-1:0] kind, input int x, input int y);
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		px = POS_W'(x);
		py = POS_W'(y);
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_DATA_W'({py, px});
		do @(posedge clk); while (!s_tready);
		pending_flags.insert(pending_flags.size(),
		                     apply_map_item(kind, $signed(px), $signed(py)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_flags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [CFG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= APB_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (!wr && prdata !== APB_W'(val))
			note_mismatch(idx.name(), APB_W'(val), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
	                         input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy);
		drain();
		apb_access(1'b1, REG_GRID_WIDTH, w);
		apb_access(1'b1, REG_GRID_HEIGHT, h);
		apb_access(1'b1, REG_ORIGIN_X, ox);
		apb_access(1'b1, REG_ORIGIN_Y, oy);
		size_x  = w;
		size_y  = h;
		shift_x = ox;
		shift_y = oy;
		apb_access(1'b0, REG_GRID_WIDTH, w);
		apb_access(1'b0, REG_GRID_HEIGHT, h);
		apb_access(1'b0, REG_ORIGIN_X, ox);
		apb_access(1'b0, REG_ORIGIN_Y, oy);
	endtask

	// sets cluster in a box so that queries elsewhere can still come out legal
	task automatic run_phase(input int count, input logic [CFG_W-1:0] w,
	                         input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] ox,
	                         input logic [CFG_W-1:0] oy);
		int roll;
		int x;
		int y;
		int a;
		int wu;
		int hu;
		int bx;
		int by;
		int bw;
		logic [KIND_W-1:0] kind;
		configure(w, h, ox, oy);
		wu = used_width();
		hu = used_height();
		bw = $urandom_range(4, 24);
		bx = $urandom_range(0, wu);
		by = $urandom_range(0, hu);
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				kind = KIND_W'($urandom_range(0, 3));
				x = int'($urandom_range(0, 2047)) - 1024;
				y = int'($urandom_range(0, 2047)) - 1024;
			end else if (roll < 62) begin
				kind = (roll < 40) ? KIND_SET : KIND_CLEAR;
				if (kind == KIND_CLEAR && recent_walls.size() != 0 &&
				    $urandom_range(0, 3) != 0) begin
					a = recent_walls[$urandom_range(0, recent_walls.size() - 1)];
					x = a / MAX_HEIGHT;
					y = a % MAX_HEIGHT;
				end else if ($urandom_range(0, 9) == 0) begin
					// anywhere, one pixel past each edge included
					x = int'($urandom_range(0, wu + 1)) - 1;
					y = int'($urandom_range(0, hu + 1)) - 1;
				end else begin
					x = bx + int'($urandom_range(0, bw - 1));
					y = by + int'($urandom_range(0, bw - 1));
				end
			end else if (roll < 96) begin
				kind = KIND_QUERY;
				x = int'($urandom_range(0, wu + 3)) - 2 - int'(ox);
				y = int'($urandom_range(0, hu + 3)) - 2 - int'(oy);
			end else begin
				kind = KIND_UNUSED;
				x = int'($urandom_range(0, 2047)) - 1024;
				y = int'($urandom_range(0, 2047)) - 1024;
			end
			send_item(kind, x, y);
		end
	endtask

	task automatic test_reset_values();
		apb_access(1'b0, REG_GRID_WIDTH, 9'd256);
		apb_access(1'b0, REG_GRID_HEIGHT, 9'd256);
		apb_access(1'b0, REG_ORIGIN_X, 9'd128);
		apb_access(1'b0, REG_ORIGIN_Y, 9'd128);
	endtask

	// default grid, origin at its middle: world = grid - 128
	task automatic test_basic_edits();
		send_item(KIND_QUERY, 0, 0);
		send_item(KIND_SET, 0, 0);
		send_item(KIND_SET, 0, 0);
		send_item(KIND_QUERY, 5 - 128, 5 - 128);
		send_item(KIND_QUERY, -128, -128);
		send_item(KIND_QUERY, 126, 126);
		send_item(KIND_SET, 255, 255);
		send_item(KIND_QUERY, 126, 126);
		send_item(KIND_CLEAR, 255, 255);
		send_item(KIND_SET, -1, 0);
		send_item(KIND_SET, 256, 0);
		send_item(KIND_CLEAR, 0, 256);
		send_item(KIND_SET, -1024, 1023);
		send_item(KIND_UNUSED, 5, 5);
		send_item(KIND_QUERY, 1023, -1024);
	endtask

	task automatic test_empty_grid();
		configure(9'd0, 9'd0, 9'd128, 9'd128);
		send_item(KIND_SET, 0, 0);
		send_item(KIND_QUERY, -128, -128);
	endtask

	task automatic test_size_clamp();
		configure(9'd511, 9'd300, 9'd128, 9'd128);
		send_item(KIND_SET, 255, 255);
		send_item(KIND_CLEAR, 255, 255);
	endtask

	// counts are not rebuilt on resize: clears can hit zero or miss pixels
	task automatic test_resize_saturation();
		configure(9'd20, 9'd20, 9'd128, 9'd128);
		send_item(KIND_SET, 15, 15);
		configure(9'd256, 9'd256, 9'd128, 9'd128);
		send_item(KIND_CLEAR, 15, 15);
		send_item(KIND_QUERY, 22 - 128, 22 - 128);
		send_item(KIND_SET, 95, 95);
		configure(9'd100, 9'd100, 9'd128, 9'd128);
		send_item(KIND_CLEAR, 95, 95);
		configure(9'd256, 9'd256, 9'd128, 9'd128);
		send_item(KIND_QUERY, 102 - 128, 102 - 128);
	endtask

	task automatic test_random_traffic();
		run_phase(200, 9'd256, 9'd256, 9'd128, 9'd128);
		run_phase(120, 9'd1, 9'd256, 9'd0, 9'd511);
		run_phase(180, 9'd511, 9'd40, 9'd300, 9'd20);
		run_phase(180, 9'd64, 9'd64, CFG_W'($urandom_range(0, 511)),
		          CFG_W'($urandom_range(0, 511)));
		stalls_on = 1'b0;
		run_phase(150, 9'd256, 9'd1, 9'd511, 9'd0);
		stalls_on = 1'b1;
		run_phase(180, 9'd256, 9'd256, 9'd0, 9'd0);
		run_phase(180, CFG_W'($urandom_range(1, 511)), CFG_W'($urandom_range(1, 511)),
		          CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)));
		run_phase(150, 9'd32, 9'd200, 9'd17, 9'd255);
	endtask

	task automatic test_no_stall_tail();
		stalls_on = 1'b0;
		run_phase(160, 9'd200, 9'd180, 9'd100, 9'd90);
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		stalls_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_basic_edits();
		test_empty_grid();
		test_size_clamp();
		test_resize_saturation();
		test_random_traffic();
		test_no_stall_tail();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_flags.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// result side backpressure in random bursts
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_flags.size() == 0) begin
				note_mismatch("unexpected result", '0, APB_W'(m_tdata));
			end else begin
				want = pending_flags.pop_front();
				if (m_tdata[0] !== want.changed)
					note_mismatch("changed", APB_W'(want.changed), APB_W'(m_tdata[0]));
				if (m_tdata[1] !== want.legal)
					note_mismatch("legal", APB_W'(want.legal), APB_W'(m_tdata[1]));
				if (m_tdata[2] !== want.out_of_range)
					note_mismatch("out_of_range", APB_W'(want.out_of_range),
					              APB_W'(m_tdata[2]));
				if (m_tdata[OUT_DATA_W-1:3] !== '0)
					note_mismatch("tdata pad", '0, APB_W'(m_tdata[OUT_DATA_W-1:3]));
			end
		end
	end

	// covers the clearing pass after reset and the slowest window update
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
